/* hw/rtl/smpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// types and constants shared by the sorted priority queue cells and top level
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } smpq_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } smpq_status_t;

    typedef struct packed {
        smpq_op_t               operation;
        logic [KEY_BITS-1:0]    cost_key;
        logic [HANDLE_BITS-1:0] item_handle;
    } smpq_in_t;

    typedef struct packed {
        smpq_status_t           status;
        logic [KEY_BITS-1:0]    out_key;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [COUNT_BITS-1:0]  occupancy;
    } smpq_out_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } smpq_entry_t;

    typedef struct packed {
        logic ins_en;
        logic pop_en;
        logic occupied;
        logic left_gt;
    } smpq_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/smpq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// one slot of the sorted chain: compares its key with the incoming key and
// keeps, loads the new entry, or takes its left or right neighbor's entry
// ----------------------------------------------------------------------------
module smpq_cell
    import smpq_pkg::*;
(
    input  wire logic        aclk,
    input  wire smpq_ctrl_t  ctrl,
    input  wire smpq_entry_t new_entry,
    input  wire smpq_entry_t left_entry,
    input  wire smpq_entry_t right_entry,
    output smpq_entry_t      entry,
    output logic             gt
);

    smpq_entry_t entry_reg;
    smpq_entry_t entry_next;

    // empty slots count as greater so the new entry lands after every stored key not greater than it
    assign gt = !ctrl.occupied || (entry_reg.key > new_entry.key);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins_en) begin
            if (gt && ctrl.left_gt) begin
                entry_next = left_entry;
            end else if (gt) begin
                entry_next = new_entry;
            end
        end else if (ctrl.pop_en) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

/* hw/rtl/stable_min_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// sorted open list built as a chain of compare-and-shift cells
// result: registered, valid in the cycle after the input transfer
// throughput: one operation per cycle while the result side is ready; every cell compares against the
//   broadcast key in parallel and shifts in the same cycle
// reset: entry count and result valid cleared; cell contents are not reset
// ----------------------------------------------------------------------------
module stable_min_priority_queue
    import smpq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire smpq_in_t s_payload,
    output logic          m_valid,
    input  wire logic     m_ready,
    output smpq_out_t     m_payload
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  m_valid_reg;
    smpq_out_t             m_payload_reg;
    smpq_out_t             result_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  do_ins;
    logic                  do_pop;
    smpq_entry_t           new_entry;
    smpq_entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0]      cell_gt;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == COUNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_ins   = accept && (s_payload.operation == OP_INSERT) && !full;
    assign do_pop   = accept && (s_payload.operation == OP_POP) && !empty;

    assign new_entry.key    = s_payload.cost_key;
    assign new_entry.handle = s_payload.item_handle;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        smpq_ctrl_t  ctrl;
        smpq_entry_t left_entry;
        smpq_entry_t right_entry;

        assign ctrl.ins_en   = do_ins;
        assign ctrl.pop_en   = do_pop;
        assign ctrl.occupied = (COUNT_BITS'(i) < count_reg);

        if (i == 0) begin : g_head
            assign ctrl.left_gt   = 1'b0;
            assign left_entry     = new_entry;
        end else begin : g_body
            assign ctrl.left_gt   = cell_gt[i-1];
            assign left_entry     = cell_entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        smpq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb begin
        count_next            = count_reg;
        result_next.status    = ST_OK;
        result_next.out_key   = '0;
        result_next.out_handle = '0;
        unique case (s_payload.operation)
            OP_INSERT: begin
                if (full) begin
                    result_next.status = ST_FULL;
                end else begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    result_next.status = ST_EMPTY;
                end else begin
                    result_next.out_key    = cell_entry[0].key;
                    result_next.out_handle = cell_entry[0].handle;
                    count_next             = count_reg - COUNT_BITS'(1);
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_NOP: begin
                count_next = count_reg;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        result_next.occupancy = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_payload_reg <= result_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // count never exceeds the chain length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("entry count beyond depth");

    // an accepted transfer always yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("no result after accepted transfer");

    // full status only when the chain is full
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == ST_FULL) |->
            m_payload.occupancy == COUNT_BITS'(DEPTH))
        else $error("full status with free slots");

    // empty status returns zero payload and zero occupancy
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status == ST_EMPTY) |->
            (m_payload.occupancy == '0 && m_payload.out_key == '0))
        else $error("empty status with nonzero fields");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the stable minimum priority queue with a directed sequence and then random valid/ready traffic.
// A scoreboard keeps its own sorted copy of the open list and checks every
// returned result against it.
// ----------------------------------------------------------------------------
module testbench;
    import smpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1930;
    localparam int DRAIN_LIMIT  = 5000;

    typedef enum {FILL_BURST, DRAIN_BURST, MIXED_BURST} burst_kind_t;

    class queue_scoreboard;
        smpq_entry_t  open_list[$];
        smpq_out_t    expected_replies[$];
        int unsigned  mismatches;

        function void flag(string what, smpq_out_t want, smpq_out_t got);
            if (mismatches < 10) begin
                $display("%s: expected st=%0d key=%h hdl=%h occ=%0d, got st=%0d key=%h hdl=%h occ=%0d",
                         what, want.status, want.out_key, want.out_handle, want.occupancy,
                         got.status, got.out_key, got.out_handle, got.occupancy);
            end
            mismatches++;
        endfunction

        function void note_request(smpq_in_t req);
            smpq_out_t   reply;
            smpq_entry_t fresh;
            int          pos;
            reply = '0;
            reply.status = ST_OK;
            case (req.operation)
                OP_INSERT: begin
                    if (open_list.size() >= DEPTH) begin
                        reply.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < open_list.size() && open_list[pos].key <= req.cost_key)
                            pos++;
                        fresh.key    = req.cost_key;
                        fresh.handle = req.item_handle;
                        open_list.insert(pos, fresh);
                    end
                end
                OP_POP: begin
                    if (open_list.size() == 0) begin
                        reply.status = ST_EMPTY;
                    end else begin
                        reply.out_key    = open_list[0].key;
                        reply.out_handle = open_list[0].handle;
                        void'(open_list.pop_front());
                    end
                end
                OP_CLEAR: begin
                    open_list.delete();
                end
                default: begin
                end
            endcase
            reply.occupancy = COUNT_BITS'(open_list.size());
            expected_replies.push_back(reply);
        endfunction

        function void check_result(smpq_out_t got);
            smpq_out_t want;
            if (expected_replies.size() == 0) begin
                flag("unexpected transfer", '0, got);
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.out_key !== want.out_key ||
                    got.out_handle !== want.out_handle || got.occupancy !== want.occupancy) begin
                    flag("mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    smpq_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    smpq_out_t m_payload;

    queue_scoreboard board = new();
    bit          steady_traffic = 1'b0;
    int unsigned stall_left = 0;

    stable_min_priority_queue uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic smpq_in_t make_item(smpq_op_t op, logic [KEY_BITS-1:0] key,
                                           logic [HANDLE_BITS-1:0] handle);
        smpq_in_t item;
        item.operation   = op;
        item.cost_key    = key;
        item.item_handle = handle;
        return item;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return KEY_BITS'($urandom_range(0, 15));
        else if (r < 40)
            return '1;
        else if (r < 43)
            return '0;
        else if (r < 46)
            return {1'b1, {(KEY_BITS-1){1'b0}}};
        else
            return KEY_BITS'($urandom);
    endfunction

    // result side: check each transfer, then decide ready for the next edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_payload);
        if (steady_traffic || !aresetn) begin
            stall_left <= 0;
            m_ready    <= aresetn;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready    <= 1'b1;
        end
    end

    task automatic send_item(smpq_in_t item);
        int unsigned gap;
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_request(item);
        gap = steady_traffic ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid   <= 1'b0;
            s_payload <= make_item(smpq_op_t'($urandom_range(0, 3)), KEY_BITS'($urandom),
                                   HANDLE_BITS'($urandom));
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        int unsigned counted;
        int unsigned burst_len;
        int unsigned r;
        int unsigned waited;
        burst_kind_t kind;
        smpq_op_t    op;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pop on empty, extremes, equal keys leaving in arrival order, nop, clear
        send_item(make_item(OP_POP, '0, '0));
        send_item(make_item(OP_INSERT, '1, '1));
        send_item(make_item(OP_INSERT, '0, '0));
        send_item(make_item(OP_INSERT, 32'd5, 16'd1));
        send_item(make_item(OP_INSERT, 32'd5, 16'd2));
        send_item(make_item(OP_INSERT, 32'd5, 16'd3));
        send_item(make_item(OP_INSERT, '1, 16'h1234));
        send_item(make_item(OP_NOP, 32'hA5A5_5A5A, 16'hC3C3));
        repeat (6) send_item(make_item(OP_POP, '1, '1));
        send_item(make_item(OP_POP, '0, '0));
        send_item(make_item(OP_INSERT, 32'd7, 16'hAAAA));
        send_item(make_item(OP_INSERT, 32'd3, 16'h5555));
        send_item(make_item(OP_CLEAR, '1, '1));
        send_item(make_item(OP_POP, '0, '0));
        send_item(make_item(OP_NOP, '0, '0));

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            kind = burst_kind_t'($urandom_range(0, 2));
            burst_len = (kind == FILL_BURST) ? $urandom_range(90, 200) : $urandom_range(20, 120);
            steady_traffic = ($urandom_range(0, 4) == 0);
            repeat (burst_len) begin
                r = $urandom_range(0, 99);
                case (kind)
                    FILL_BURST:  op = (r < 84) ? OP_INSERT : (r < 97) ? OP_POP :
                                      (r < 98) ? OP_CLEAR : OP_NOP;
                    DRAIN_BURST: op = (r < 20) ? OP_INSERT : (r < 97) ? OP_POP :
                                      (r < 98) ? OP_CLEAR : OP_NOP;
                    default:     op = (r < 48) ? OP_INSERT : (r < 94) ? OP_POP :
                                      (r < 97) ? OP_CLEAR : OP_NOP;
                endcase
                send_item(make_item(op, pick_key(), HANDLE_BITS'($urandom_range(0, 65535))));
                counted++;
                if (counted >= RANDOM_ITEMS)
                    break;
            end
        end
        steady_traffic = 1'b0;
        s_valid <= 1'b0;

        waited = 0;
        while (board.expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (board.expected_replies.size() != 0)
            board.mismatches++;

        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule
